>>> src/hts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the Huffman table stream decoder.
// ----------------------------------------------------------------------------
package hts_pkg;

    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_MAX_CODE_LEN  = 24;

    localparam int KIND_W       = 2;
    localparam int INDEX_W      = 8;
    localparam int SYM_W        = 8;
    localparam int ENTRY_LEN_W  = 5;
    localparam int ENTRY_CODE_W = 24;
    localparam int TOTAL_W      = 31;
    localparam int BYTE_W       = 8;
    localparam int BIT_IDX_W    = 3;
    localparam int MAX_SYMS     = 8;
    localparam int SYM_CNT_W    = 4;
    localparam int BUF_IDX_W    = 3;

    // Entries per group of the first level of the match reduction.
    localparam int GROUP_SIZE = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_START = 2'd2,
        KIND_BYTE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_SEL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sel;
        logic emit;
    } hts_cmd_t;

    typedef struct packed {
        logic stream_done;
        logic bit_last;
        logic emit_last;
    } hts_stat_t;

endpackage

>>> src/hts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_ctrl
// Sequencer: takes requests, steps the datapath through each coded bit and
// through the delivery of the results.
// ----------------------------------------------------------------------------
module hts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  hts_pkg::hts_stat_t stat,
    output hts_pkg::hts_cmd_t cmd,
    output logic              busy
);
    import hts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == KIND_BYTE) ? ST_CMP : ST_EMIT;
                end
            end
            ST_CMP:
            begin
                state_next = stat.stream_done ? ST_EMIT : ST_GRP;
            end
            ST_GRP:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                state_next = stat.bit_last ? ST_EMIT : ST_CMP;
            end
            ST_EMIT:
            begin
                if (stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CMP:
            begin
                cmd.cmp = !stat.stream_done;
            end
            ST_GRP:
            begin
                cmd = '0;
            end
            ST_SEL:
            begin
                cmd.sel = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/hts_cam.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_cam
// Code table held in cells, compared in parallel against the probe code,
// with a two-level registered lowest-index reduction of the match vector.
// ----------------------------------------------------------------------------
module hts_cam
#(
    parameter int TABLE_ENTRIES = hts_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = hts_pkg::DEF_MAX_CODE_LEN
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    clear,
    input  logic                                    wr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]        wr_index,
    input  logic [hts_pkg::SYM_W-1:0]               wr_symbol,
    input  logic [hts_pkg::ENTRY_LEN_W-1:0]         wr_length,
    input  logic [hts_pkg::ENTRY_CODE_W-1:0]        wr_code,
    input  logic [MAX_CODE_LEN-1:0]                 probe_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]       probe_len,
    output logic                                    hit,
    output logic [hts_pkg::SYM_W-1:0]               hit_symbol
);
    import hts_pkg::*;

    localparam int IW   = $clog2(TABLE_ENTRIES);
    localparam int LW   = $clog2(MAX_CODE_LEN + 1);
    localparam int EW   = (MAX_CODE_LEN > ENTRY_CODE_W) ? MAX_CODE_LEN : ENTRY_CODE_W;
    localparam int CLW  = (LW > ENTRY_LEN_W) ? LW : ENTRY_LEN_W;
    localparam int NG   = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NPAD = NG * GROUP_SIZE;

    logic                    valid_reg [TABLE_ENTRIES];
    logic [SYM_W-1:0]        sym_reg   [TABLE_ENTRIES];
    logic [ENTRY_LEN_W-1:0]  len_reg   [TABLE_ENTRIES];
    logic [ENTRY_CODE_W-1:0] code_reg  [TABLE_ENTRIES];

    logic [EW-1:0]           mask;
    logic [EW-1:0]           probe_ext;
    logic [NPAD-1:0]         match_next;
    logic [NPAD-1:0]         match_reg;
    logic [SYM_W-1:0]        sym_pad   [NPAD];
    logic [NG-1:0]           grp_hit_next;
    logic [NG-1:0]           grp_hit_reg;
    logic [SYM_W-1:0]        grp_sym_next [NG];
    logic [SYM_W-1:0]        grp_sym_reg  [NG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                if (clear)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (wr_en && (wr_index == IW'(k)))
                begin
                    valid_reg[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (wr_en && (wr_index == IW'(k)))
            begin
                sym_reg[k]  <= wr_symbol;
                len_reg[k]  <= wr_length;
                code_reg[k] <= wr_code;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < EW; i++)
        begin
            mask[i] = (CLW'(i) < CLW'(probe_len));
        end
        probe_ext = EW'(probe_code);
    end

    // Each cell compares its own entry; the probe length is never zero and
    // never above the maximum, so only storable lengths can match.
    genvar gk;
    generate
        for (gk = 0; gk < NPAD; gk++)
        begin : g_cell
            if (gk < TABLE_ENTRIES)
            begin : g_live
                assign match_next[gk] = valid_reg[gk]
                    && (CLW'(len_reg[gk]) == CLW'(probe_len))
                    && ((EW'(code_reg[gk]) & mask) == probe_ext);
                assign sym_pad[gk] = sym_reg[gk];
            end
            else
            begin : g_pad
                assign match_next[gk] = 1'b0;
                assign sym_pad[gk]    = '0;
            end
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_hit_next[g] = |match_reg[g*GROUP_SIZE +: GROUP_SIZE];
            grp_sym_next[g] = '0;
            for (int j = GROUP_SIZE - 1; j >= 0; j--)
            begin
                if (match_reg[g*GROUP_SIZE + j])
                begin
                    grp_sym_next[g] = sym_pad[g*GROUP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        for (int g = 0; g < NG; g++)
        begin
            grp_hit_reg[g] <= grp_hit_next[g];
            grp_sym_reg[g] <= grp_sym_next[g];
        end
    end

    always_comb
    begin
        hit        = |grp_hit_reg;
        hit_symbol = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                hit_symbol = grp_sym_reg[g];
            end
        end
    end

endmodule

>>> src/hts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_dp
// Datapath: partial code, stream counters, symbol buffer and result register.
// ----------------------------------------------------------------------------
module hts_dp
#(
    parameter int TABLE_ENTRIES = hts_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = hts_pkg::DEF_MAX_CODE_LEN
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  hts_pkg::hts_cmd_t                 cmd,
    output hts_pkg::hts_stat_t                stat,
    input  logic [hts_pkg::KIND_W-1:0]        kind,
    input  logic [hts_pkg::INDEX_W-1:0]       entry_index,
    input  logic [hts_pkg::SYM_W-1:0]         entry_symbol,
    input  logic [hts_pkg::ENTRY_LEN_W-1:0]   entry_length,
    input  logic [hts_pkg::ENTRY_CODE_W-1:0]  entry_code,
    input  logic [hts_pkg::TOTAL_W-1:0]       symbol_total,
    input  logic [hts_pkg::BYTE_W-1:0]        coded_byte,
    output logic                              strobe,
    output logic [hts_pkg::SYM_W-1:0]         symbol,
    output logic                              symbol_valid,
    output logic                              last,
    output logic                              stream_done,
    output logic                              code_overflow
);
    import hts_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int PW = MAX_CODE_LEN;

    logic [BYTE_W-1:0]    byte_reg;
    logic [BYTE_W-1:0]    byte_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg;
    logic [BIT_IDX_W-1:0] bit_idx_next;
    logic [PW-1:0]        pcode_reg;
    logic [PW-1:0]        pcode_next;
    logic [LW-1:0]        plen_reg;
    logic [LW-1:0]        plen_next;
    logic [TOTAL_W-1:0]   decoded_reg;
    logic [TOTAL_W-1:0]   decoded_next;
    logic [TOTAL_W-1:0]   target_reg;
    logic [TOTAL_W-1:0]   target_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic [SYM_CNT_W-1:0] cnt_reg;
    logic [SYM_CNT_W-1:0] cnt_next;
    logic [BUF_IDX_W-1:0] emit_idx_reg;
    logic [BUF_IDX_W-1:0] emit_idx_next;
    logic [SYM_W-1:0]     buf_reg [MAX_SYMS];

    logic                 strobe_reg;
    logic [SYM_W-1:0]     symbol_reg;
    logic                 symbol_valid_reg;
    logic                 last_reg;
    logic                 done_out_reg;
    logic                 ovf_out_reg;

    logic                 full;
    logic                 cur_bit;
    logic [PW-1:0]        probe_code;
    logic [LW-1:0]        probe_len;
    logic                 done;
    logic                 clear;
    logic                 wr_en;
    logic                 hit;
    logic [SYM_W-1:0]     hit_symbol;

    assign done    = (decoded_reg >= target_reg);
    assign cur_bit = byte_reg[bit_idx_reg];
    assign full    = (plen_reg >= LW'(MAX_CODE_LEN));

    // A full partial code is dropped and the new bit opens a fresh code.
    assign probe_code = full ? PW'(cur_bit) : {pcode_reg[PW-2:0], cur_bit};
    assign probe_len  = full ? LW'(1) : plen_reg + LW'(1);

    assign clear = cmd.load && (kind == KIND_CLEAR);
    assign wr_en = cmd.load && (kind == KIND_LOAD)
                   && ({1'b0, entry_index} < (INDEX_W + 1)'(TABLE_ENTRIES));

    assign stat.stream_done = done;
    assign stat.bit_last    = (bit_idx_reg == '0);
    assign stat.emit_last   = (cnt_reg == '0)
                              || ((SYM_CNT_W'(emit_idx_reg) + SYM_CNT_W'(1)) == cnt_reg);

    hts_cam #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_cam (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (clear),
        .wr_en      (wr_en),
        .wr_index   (entry_index[IW-1:0]),
        .wr_symbol  (entry_symbol),
        .wr_length  (entry_length),
        .wr_code    (entry_code),
        .probe_code (probe_code),
        .probe_len  (probe_len),
        .hit        (hit),
        .hit_symbol (hit_symbol)
    );

    always_comb
    begin
        byte_next     = byte_reg;
        bit_idx_next  = bit_idx_reg;
        pcode_next    = pcode_reg;
        plen_next     = plen_reg;
        decoded_next  = decoded_reg;
        target_next   = target_reg;
        flag_next     = flag_reg;
        cnt_next      = cnt_reg;
        emit_idx_next = emit_idx_reg;

        if (cmd.load)
        begin
            cnt_next      = '0;
            emit_idx_next = '0;
            byte_next     = coded_byte;
            bit_idx_next  = BIT_IDX_W'(BYTE_W - 1);
            if (kind == KIND_START)
            begin
                target_next  = symbol_total;
                decoded_next = '0;
                pcode_next   = '0;
                plen_next    = '0;
                flag_next    = 1'b0;
            end
        end

        if (cmd.cmp)
        begin
            pcode_next = probe_code;
            plen_next  = probe_len;
            if (full)
            begin
                flag_next = 1'b1;
            end
        end

        if (cmd.sel)
        begin
            bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
            if (hit)
            begin
                pcode_next   = '0;
                plen_next    = '0;
                decoded_next = decoded_reg + TOTAL_W'(1);
                cnt_next     = cnt_reg + SYM_CNT_W'(1);
            end
        end

        if (cmd.emit)
        begin
            emit_idx_next = emit_idx_reg + BUF_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_idx_reg  <= '0;
            pcode_reg    <= '0;
            plen_reg     <= '0;
            decoded_reg  <= '0;
            target_reg   <= '0;
            flag_reg     <= 1'b0;
            cnt_reg      <= '0;
            emit_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            bit_idx_reg  <= bit_idx_next;
            pcode_reg    <= pcode_next;
            plen_reg     <= plen_next;
            decoded_reg  <= decoded_next;
            target_reg   <= target_next;
            flag_reg     <= flag_next;
            cnt_reg      <= cnt_next;
            emit_idx_reg <= emit_idx_next;
            strobe_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (cmd.sel && hit)
        begin
            buf_reg[cnt_reg[BUF_IDX_W-1:0]] <= hit_symbol;
        end
        if (cmd.emit)
        begin
            symbol_reg       <= (cnt_reg != '0) ? buf_reg[emit_idx_reg] : '0;
            symbol_valid_reg <= (cnt_reg != '0);
            last_reg         <= stat.emit_last;
            done_out_reg     <= done;
            ovf_out_reg      <= flag_reg;
        end
    end

    assign strobe        = strobe_reg;
    assign symbol        = symbol_reg;
    assign symbol_valid  = symbol_valid_reg;
    assign last          = last_reg;
    assign stream_done   = done_out_reg;
    assign code_overflow = ovf_out_reg;

endmodule

>>> src/huffman_table_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_stream_decoder
// Decodes a Huffman-coded byte stream against a loaded code table.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Signals
//  request   start / busy     kind, entry_*, symbol_total, coded_byte
//  result    strobe           symbol, symbol_valid, last, stream_done,
//                             code_overflow
//
//  A request is taken when start is high and busy is low.
//  Table and start requests give one registered result each.
//  A coded byte steps each bit through compare, group reduce and select
//  until the total is reached, then gives one to eight results.
//  Reset invalidates the whole table at once; no clearing pass is needed.
//  Results are shown for one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module huffman_table_stream_decoder
#(
    parameter int TABLE_ENTRIES = hts_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = hts_pkg::DEF_MAX_CODE_LEN
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hts_pkg::KIND_W-1:0]        kind,
    input  logic [hts_pkg::INDEX_W-1:0]       entry_index,
    input  logic [hts_pkg::SYM_W-1:0]         entry_symbol,
    input  logic [hts_pkg::ENTRY_LEN_W-1:0]   entry_length,
    input  logic [hts_pkg::ENTRY_CODE_W-1:0]  entry_code,
    input  logic [hts_pkg::TOTAL_W-1:0]       symbol_total,
    input  logic [hts_pkg::BYTE_W-1:0]        coded_byte,
    output logic                              strobe,
    output logic [hts_pkg::SYM_W-1:0]         symbol,
    output logic                              symbol_valid,
    output logic                              last,
    output logic                              stream_done,
    output logic                              code_overflow
);
    import hts_pkg::*;

    hts_cmd_t  cmd;
    hts_stat_t stat;

    hts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    hts_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_symbol  (entry_symbol),
        .entry_length  (entry_length),
        .entry_code    (entry_code),
        .symbol_total  (symbol_total),
        .coded_byte    (coded_byte),
        .strobe        (strobe),
        .symbol        (symbol),
        .symbol_valid  (symbol_valid),
        .last          (last),
        .stream_done   (stream_done),
        .code_overflow (code_overflow)
    );

    // A result is only ever produced while a request is in progress.
    a_result_in_request: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result outside a request");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result after the final result of a request");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !symbol_valid) |-> last)
        else $error("empty result not marked last");

endmodule

>>> verif/tb_huffman_table_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_stream_decoder
// Self-checking bench for the Huffman table stream decoder. A scoreboard
// class predicts the results of every accepted request from its own copy of
// the code table and stream state, and checks each strobed result in order.
// A directed opening is followed by random sessions that clear the table,
// load a random prefix code, start a stream and feed coded bytes.
// ----------------------------------------------------------------------------
module tb_huffman_table_stream_decoder;

    import hts_pkg::*;

    localparam int TABLE_N     = DEF_TABLE_ENTRIES;
    localparam int CODE_MAX    = DEF_MAX_CODE_LEN;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        kind_t                   kind;
        logic [INDEX_W-1:0]      entry_index;
        logic [SYM_W-1:0]        entry_symbol;
        logic [ENTRY_LEN_W-1:0]  entry_length;
        logic [ENTRY_CODE_W-1:0] entry_code;
        logic [TOTAL_W-1:0]      symbol_total;
        logic [BYTE_W-1:0]       coded_byte;
    } hts_request_t;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic             last;
        logic             stream_done;
        logic             code_overflow;
    } decoded_result_t;

    class huff_scoreboard;
        bit                      tab_valid [TABLE_N];
        logic [ENTRY_LEN_W-1:0]  tab_len   [TABLE_N];
        logic [ENTRY_CODE_W-1:0] tab_code  [TABLE_N];
        logic [SYM_W-1:0]        tab_sym   [TABLE_N];
        logic [ENTRY_CODE_W-1:0] partial_bits;
        int unsigned             partial_len;
        int unsigned             decoded_cnt;
        int unsigned             target_cnt;
        bit                      overflow_seen;
        decoded_result_t         expected_results [$];
        int                      mismatches;

        function new();
            wipe_table();
            partial_bits  = '0;
            partial_len   = 0;
            decoded_cnt   = 0;
            target_cnt    = 0;
            overflow_seen = 1'b0;
            mismatches    = 0;
        endfunction

        function void wipe_table();
            for (int i = 0; i < TABLE_N; i++)
            begin
                tab_valid[i] = 1'b0;
                tab_len[i]   = '0;
                tab_code[i]  = '0;
                tab_sym[i]   = '0;
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Works out the results of one accepted request and queues them.
        function void note_request(hts_request_t r);
            logic [SYM_W-1:0]        syms [MAX_SYMS];
            logic [ENTRY_CODE_W-1:0] mask;
            decoded_result_t         res;
            int                      count;
            int                      hit;
            int                      n;
            count = 0;
            case (r.kind)
                KIND_CLEAR:
                begin
                    wipe_table();
                end
                KIND_LOAD:
                begin
                    if (r.entry_index < TABLE_N)
                    begin
                        tab_valid[r.entry_index] = 1'b1;
                        tab_sym[r.entry_index]   = r.entry_symbol;
                        tab_len[r.entry_index]   = r.entry_length;
                        tab_code[r.entry_index]  = r.entry_code;
                    end
                end
                KIND_START:
                begin
                    target_cnt    = 32'(r.symbol_total);
                    decoded_cnt   = 0;
                    partial_bits  = '0;
                    partial_len   = 0;
                    overflow_seen = 1'b0;
                end
                default:
                begin
                    for (int b = BYTE_W - 1; b >= 0; b--)
                    begin
                        // Once the total is reached the remaining bits are dropped.
                        if (decoded_cnt < target_cnt)
                        begin
                            if (partial_len >= CODE_MAX)
                            begin
                                overflow_seen = 1'b1;
                                partial_bits  = '0;
                                partial_len   = 0;
                            end
                            partial_bits = {partial_bits[ENTRY_CODE_W-2:0], r.coded_byte[b]};
                            partial_len++;
                            mask = ~({ENTRY_CODE_W{1'b1}} << partial_len);
                            hit  = -1;
                            for (int i = 0; i < TABLE_N; i++)
                            begin
                                if (hit < 0 && tab_valid[i] && tab_len[i] == partial_len &&
                                    (tab_code[i] & mask) == partial_bits)
                                    hit = i;
                            end
                            if (hit >= 0)
                            begin
                                if (count < MAX_SYMS)
                                begin
                                    syms[count] = tab_sym[hit];
                                    count++;
                                end
                                decoded_cnt++;
                                partial_bits = '0;
                                partial_len  = 0;
                            end
                        end
                    end
                end
            endcase
            n = (count > 0) ? count : 1;
            for (int k = 0; k < n; k++)
            begin
                res.symbol        = (count > 0) ? syms[k] : '0;
                res.symbol_valid  = (count > 0);
                res.last          = (k == n - 1);
                res.stream_done   = (decoded_cnt >= target_cnt);
                res.code_overflow = overflow_seen;
                expected_results.insert(expected_results.size(), res);
            end
        endfunction

        function void compare_field(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s: expected %0h, got %0h", field, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(logic [SYM_W-1:0] sym, logic valid, logic lst,
                                   logic done, logic ovf);
            decoded_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: symbol %0h valid %0b", sym, valid);
                mismatches++;
            end
            else
            begin
                e = expected_results.pop_front();
                compare_field("symbol", 32'(e.symbol), 32'(sym));
                compare_field("symbol_valid", 32'(e.symbol_valid), 32'(valid));
                compare_field("last", 32'(e.last), 32'(lst));
                compare_field("stream_done", 32'(e.stream_done), 32'(done));
                compare_field("code_overflow", 32'(e.code_overflow), 32'(ovf));
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [KIND_W-1:0]       kind;
    logic [INDEX_W-1:0]      entry_index;
    logic [SYM_W-1:0]        entry_symbol;
    logic [ENTRY_LEN_W-1:0]  entry_length;
    logic [ENTRY_CODE_W-1:0] entry_code;
    logic [TOTAL_W-1:0]      symbol_total;
    logic [BYTE_W-1:0]       coded_byte;
    logic                    strobe;
    logic [SYM_W-1:0]        symbol;
    logic                    symbol_valid;
    logic                    last;
    logic                    stream_done;
    logic                    code_overflow;

    huff_scoreboard sb;
    int             sender_idle_pct;
    int             requests_sent;
    int             cycle_count;

    huffman_table_stream_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .entry_index   (entry_index),
        .entry_symbol  (entry_symbol),
        .entry_length  (entry_length),
        .entry_code    (entry_code),
        .symbol_total  (symbol_total),
        .coded_byte    (coded_byte),
        .strobe        (strobe),
        .symbol        (symbol),
        .symbol_valid  (symbol_valid),
        .last          (last),
        .stream_done   (stream_done),
        .code_overflow (code_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_huffman_table_stream_decoder: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (strobe)
            sb.check_result(symbol, symbol_valid, last, stream_done, code_overflow);
    end

    function automatic hts_request_t noise_request();
        hts_request_t r;
        r.kind         = kind_t'($urandom_range(0, 3));
        r.entry_index  = INDEX_W'($urandom_range(0, 255));
        r.entry_symbol = SYM_W'($urandom_range(0, 255));
        r.entry_length = ENTRY_LEN_W'($urandom_range(0, 31));
        r.entry_code   = ENTRY_CODE_W'($urandom());
        r.symbol_total = TOTAL_W'($urandom());
        r.coded_byte   = BYTE_W'($urandom_range(0, 255));
        return r;
    endfunction

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance.
    task automatic issue(input hts_request_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        kind         <= r.kind;
        entry_index  <= r.entry_index;
        entry_symbol <= r.entry_symbol;
        entry_length <= r.entry_length;
        entry_code   <= r.entry_code;
        symbol_total <= r.symbol_total;
        coded_byte   <= r.coded_byte;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_clear();
        hts_request_t r;
        r      = noise_request();
        r.kind = KIND_CLEAR;
        issue(r);
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [SYM_W-1:0] sym,
                             input logic [ENTRY_LEN_W-1:0] len,
                             input logic [ENTRY_CODE_W-1:0] code);
        hts_request_t r;
        r              = noise_request();
        r.kind         = KIND_LOAD;
        r.entry_index  = idx;
        r.entry_symbol = sym;
        r.entry_length = len;
        r.entry_code   = code;
        issue(r);
    endtask

    task automatic send_start(input logic [TOTAL_W-1:0] total);
        hts_request_t r;
        r              = noise_request();
        r.kind         = KIND_START;
        r.symbol_total = total;
        issue(r);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        hts_request_t r;
        r            = noise_request();
        r.kind       = KIND_BYTE;
        r.coded_byte = b;
        issue(r);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // One stream: a table built from a random prefix code, a start and a run of
    // coded bytes. Some sessions are plain noise or leave out part of the set-up.
    task automatic run_session();
        logic [ENTRY_CODE_W-1:0] leaf_code [32];
        logic [ENTRY_CODE_W-1:0] mask;
        int                      leaf_len  [32];
        int                      leaves;
        int                      wanted;
        int                      pick;
        int                      skipped;
        int                      base;
        bit                      chain;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
                issue(noise_request());
            return;
        end
        // A chain code has one long run of ones, which reaches the longest lengths.
        chain       = ($urandom_range(0, 3) == 0);
        leaf_code[0] = '0;
        leaf_code[1] = ENTRY_CODE_W'(1);
        leaf_len[0]  = 1;
        leaf_len[1]  = 1;
        leaves       = 2;
        wanted       = chain ? $urandom_range(8, CODE_MAX + 1) : $urandom_range(2, 10);
        while (leaves < wanted)
        begin
            pick = chain ? leaves - 1 : $urandom_range(0, leaves - 1);
            if (leaf_len[pick] < CODE_MAX)
            begin
                leaf_code[leaves] = {leaf_code[pick][ENTRY_CODE_W-2:0], 1'b1};
                leaf_len[leaves]  = leaf_len[pick] + 1;
                leaf_code[pick]   = {leaf_code[pick][ENTRY_CODE_W-2:0], 1'b0};
                leaf_len[pick]++;
                leaves++;
            end
        end
        // An incomplete table lets the partial code run past the longest length.
        skipped = ($urandom_range(0, 4) == 0) ? $urandom_range(0, leaves - 1) : -1;
        base    = $urandom_range(0, 255);
        if ($urandom_range(0, 9) != 0)
            send_clear();
        for (int i = 0; i < leaves; i++)
        begin
            if (i != skipped)
            begin
                mask = ~({ENTRY_CODE_W{1'b1}} << leaf_len[i]);
                send_load(INDEX_W'((base + i) % TABLE_N), SYM_W'($urandom_range(0, 255)),
                          ENTRY_LEN_W'(leaf_len[i]),
                          ENTRY_CODE_W'(leaf_code[i] | ($urandom() & ~mask)));
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_start(TOTAL_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 40)));
        repeat ($urandom_range(1, 14))
        begin
            if ($urandom_range(0, 19) == 0)
                issue(noise_request());
            if (chain && $urandom_range(0, 2) == 0)
                send_byte(8'hFF);
            else
                send_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb              = new();
        sender_idle_pct = 0;
        requests_sent   = 0;
        cycle_count     = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        kind            = KIND_CLEAR;
        entry_index     = '0;
        entry_symbol    = '0;
        entry_length    = '0;
        entry_code      = '0;
        symbol_total    = '0;
        coded_byte      = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the stream already counts as done, so this byte is ignored.
        send_byte(8'hFF);
        send_clear();
        send_load(8'd0, 8'h41, 5'd1, 24'h000000);
        send_load(8'd1, 8'h42, 5'd2, 24'h000002);
        send_load(8'd2, 8'h00, 5'd3, 24'h000006);
        // Bits above the code length must play no part in the match.
        send_load(8'd255, 8'hFF, 5'd3, 24'hFFFFFF);
        // Same code as slot zero; the lower slot has to win.
        send_load(8'd3, 8'h99, 5'd1, 24'h000000);
        send_load(8'd4, 8'h55, 5'd0, 24'h000000);
        send_load(8'd5, 8'hAA, 5'd31, 24'h000001);
        send_start(31'd0);
        send_byte(8'h00);
        send_start(31'h7FFFFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        // The total is reached inside the byte; the rest of it is dropped.
        send_start(31'd3);
        send_byte(8'h00);
        send_clear();
        send_load(8'd7, 8'h7E, 5'd24, 24'hABCDEF);
        send_start(31'd5);
        send_byte(8'hAB);
        send_byte(8'hCD);
        send_byte(8'hEF);
        repeat (4) send_byte(8'h00);
        wait_for_results();

        sender_idle_pct = 37;
        while (requests_sent < 160)
            run_session();
        wait_for_results();
        sender_idle_pct = 74;
        while (requests_sent < 295)
            run_session();
        wait_for_results();
        sender_idle_pct = 0;
        while (requests_sent < 430)
            run_session();

        wait_for_results();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (sb.mismatches == 0)
            $display("tb_huffman_table_stream_decoder: done, clean");
        else
            $display("tb_huffman_table_stream_decoder: done, errors");
        $finish;
    end

endmodule
